>>> rtl/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII converter.
`default_nettype none
package sitda_pkg;
  localparam int IN_W          = 64;
  localparam int TEXT_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int DIGIT_DEPTH   = 19;
  localparam int PTR_W         = 5;
  localparam int BITS_PER_STEP = 4;

  localparam logic [TEXT_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [TEXT_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DABBLE_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ    = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;
endpackage
`default_nettype wire

>>> rtl/sitda_front.sv
// Front end: takes the input value apart into sign and unsigned magnitude.
`default_nettype none
module sitda_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic [sitda_pkg::IN_W-1:0] value,
  output logic                            neg,
  output logic [VALUE_WIDTH-1:0]          mag
);
  logic [VALUE_WIDTH-1:0] raw;

  assign raw = value[VALUE_WIDTH-1:0];
  assign neg = raw[VALUE_WIDTH-1];
  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
endmodule
`default_nettype wire

>>> rtl/sitda_fifo.sv
// Two-entry queue between the front end and the digit engine.
`default_nettype none
module sitda_fifo #(
  parameter int DATA_W = 65
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rdata,
  output logic                   empty
);
  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("queue pointers disagree with count");
endmodule
`default_nettype wire

>>> rtl/sitda_back.sv
// Digit engine: shift-add-3 binary to BCD, leading-zero sizing, character output register.
`default_nettype none
module sitda_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  input  wire logic                             q_neg,
  input  wire logic [VALUE_WIDTH-1:0]           q_mag,
  output logic                                  q_pop,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [sitda_pkg::TEXT_W-1:0]          out_text_byte,
  output logic                                  out_last_byte
);
  localparam int STEPS      = (VALUE_WIDTH + sitda_pkg::BITS_PER_STEP - 1)
                              / sitda_pkg::BITS_PER_STEP;
  localparam int PAD_W      = STEPS * sitda_pkg::BITS_PER_STEP;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int BCD_W      = sitda_pkg::DIGIT_DEPTH * sitda_pkg::DIGIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  typedef logic [sitda_pkg::DIGIT_DEPTH-1:0][sitda_pkg::DIGIT_W-1:0] bcd_t;

  logic [1:0]                   state_r, state_nxt;
  logic [PAD_W-1:0]             mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  bcd_t                         bcd_r, bcd_nxt, bcd_step;
  logic [STEP_CNT_W-1:0]        step_r, step_nxt;
  logic [sitda_pkg::PTR_W-1:0]  dig_ptr_r, dig_ptr_nxt;
  logic                         sign_pend_r, sign_pend_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sitda_pkg::TEXT_W-1:0] out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_free, emit;
  logic [sitda_pkg::TEXT_W-1:0] emit_byte;
  logic                         emit_last;
  logic [sitda_pkg::PTR_W-1:0]  size_cnt;

  assign out_free      = ~out_valid_r | out_pop;
  assign out_empty     = ~out_valid_r;
  assign out_text_byte = out_byte_r;
  assign out_last_byte = out_last_r;

  // Four shift-add-3 steps per cycle, top magnitude bits first.
  always_comb begin
    bcd_t             tmp;
    logic [BCD_W-1:0] flat;
    logic [PAD_W-1:0] m;
    tmp = bcd_r;
    m   = mag_r;
    for (int s = 0; s < sitda_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < sitda_pkg::DIGIT_DEPTH; d++) begin
        if (tmp[d] >= sitda_pkg::DABBLE_THRESH) begin
          tmp[d] = tmp[d] + sitda_pkg::DABBLE_ADJ;
        end
      end
      // Shift the whole digit string as one flat vector.
      flat = tmp;
      flat = {flat[BCD_W-2:0], m[PAD_W-1]};
      tmp  = flat;
      m    = m << 1;
    end
    bcd_step = tmp;
  end

  // Number of significant digits, at least one so zero prints as '0'.
  always_comb begin
    size_cnt = {{(sitda_pkg::PTR_W-1){1'b0}}, 1'b1};
    for (int i = 0; i < sitda_pkg::DIGIT_DEPTH; i++) begin
      if (bcd_r[i] != '0) begin
        size_cnt = sitda_pkg::PTR_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    dig_ptr_nxt   = dig_ptr_r;
    sign_pend_nxt = sign_pend_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    emit_byte     = sitda_pkg::ASCII_MINUS;
    emit_last     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mag_nxt   = PAD_W'(q_mag);
          neg_nxt   = q_neg;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt  = bcd_step;
        mag_nxt  = mag_r << sitda_pkg::BITS_PER_STEP;
        step_nxt = step_r + {{(STEP_CNT_W-1){1'b0}}, 1'b1};
        if (step_r == STEP_CNT_W'(STEPS - 1)) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        dig_ptr_nxt   = size_cnt - {{(sitda_pkg::PTR_W-1){1'b0}}, 1'b1};
        sign_pend_nxt = neg_r;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;
          end else begin
            emit_byte = sitda_pkg::ASCII_ZERO
                        + {{(sitda_pkg::TEXT_W-sitda_pkg::DIGIT_W){1'b0}}, bcd_r[dig_ptr_r]};
            emit_last = (dig_ptr_r == '0);
            if (dig_ptr_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              dig_ptr_nxt = dig_ptr_r - {{(sitda_pkg::PTR_W-1){1'b0}}, 1'b1};
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      dig_ptr_r   <= '0;
      sign_pend_r <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dig_ptr_r   <= dig_ptr_nxt;
      sign_pend_r <= sign_pend_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (dig_ptr_r < sitda_pkg::PTR_W'(sitda_pkg::DIGIT_DEPTH)))
    else $error("digit pointer beyond digit store");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_CONV && step_r == '0))
    else $error("queue popped without starting a conversion");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == ST_IDLE && !sign_pend_r))
    else $error("final character did not end the run");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (step_r <= STEP_CNT_W'(STEPS - 1)))
    else $error("conversion step count out of range");
endmodule
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii_core.sv
// Top level: signed integer to decimal ASCII text converter.
// Each value pushed in comes out as its decimal text, one ASCII byte per pop,
// most significant character first, with a leading '-' for negative values and
// the final character flagged on out_last_byte. Only the low VALUE_WIDTH bits of
// in_value are used. Per value the digit engine loads it from the queue, runs the
// shift-add-3 unit at 4 bits a cycle, sizes the digit string, and then emits one
// character per cycle when pops keep up. A two-entry queue in front lets two
// further values be pushed while one converts.
`default_nettype none
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic signed [sitda_pkg::IN_W-1:0] in_value,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [sitda_pkg::TEXT_W-1:0]         out_text_byte,
  output logic                                 out_last_byte
);
  logic                   f_neg;
  logic [VALUE_WIDTH-1:0] f_mag;
  logic [VALUE_WIDTH:0]   q_rdata;
  logic                   q_empty;
  logic                   q_pop;

  sitda_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .value (in_value),
    .neg   (f_neg),
    .mag   (f_mag)
  );

  sitda_fifo #(.DATA_W(VALUE_WIDTH + 1)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({f_neg, f_mag}),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sitda_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_neg         (q_rdata[VALUE_WIDTH]),
    .q_mag         (q_rdata[VALUE_WIDTH-1:0]),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_byte (out_text_byte),
    .out_last_byte (out_last_byte)
  );
endmodule
`default_nettype wire

>>> test/tb_signed_int_to_decimal_ascii_core.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`default_nettype none
module tb_signed_int_to_decimal_ascii_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = 64;
  localparam int RADIX       = 10;
  localparam int RAND_ITEMS  = 480;
  localparam int DRAIN_WAIT  = 60;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TABLE_ROWS  = 22;

  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [sitda_pkg::TEXT_W-1:0] text_byte;
    logic                         last_byte;
  } text_char_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  logic [sitda_pkg::IN_W-1:0]   in_value;
  logic                         out_empty;
  logic                         out_pop;
  logic [sitda_pkg::TEXT_W-1:0] out_text_byte;
  logic                         out_last_byte;

  text_char_t expected_chars[$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         send_calm   = 0;

  // Directed rows: an empty text means the predictor supplies the expectation.
  logic [63:0] table_value [TABLE_ROWS] = '{
    64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
    VAL_MAX, VAL_MIN, VAL_MIN + 64'd1, 64'd1000000000000000000,
    64'd999999999999999999, -64'd1000000000000000000,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
    -64'd7, 64'd0, 64'd12345, -64'd9
  };
  string table_text [TABLE_ROWS] = '{
    "0", "1", "-1", "9", "10", "-10", "99", "100",
    "9223372036854775807", "-9223372036854775808", "-9223372036854775807",
    "1000000000000000000", "", "-1000000000000000000",
    "", "", "", "", "-7", "0", "", ""
  };

  signed_int_to_decimal_ascii_core #(.VALUE_WIDTH(VW)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_value     (in_value),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_text_byte(out_text_byte),
    .out_last_byte(out_last_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the decimal text of one value and queue its characters.
  function automatic void queue_decimal_text(logic [63:0] value);
    logic [63:0]                   mask;
    logic [63:0]                   raw;
    logic [63:0]                   magnitude;
    logic [sitda_pkg::DIGIT_W-1:0] digits [sitda_pkg::DIGIT_DEPTH];
    logic                          negative;
    int                            count;
    mask      = (VW == 64) ? '1 : ((64'd1 << VW) - 64'd1);
    raw       = value & mask;
    negative  = raw[VW-1];
    magnitude = negative ? ((~raw + 64'd1) & mask) : raw;
    count     = 0;
    do begin
      digits[count] = sitda_pkg::DIGIT_W'(magnitude % RADIX);
      count++;
      magnitude = magnitude / RADIX;
    end while (magnitude != 0 && count < sitda_pkg::DIGIT_DEPTH);
    if (negative)
      expected_chars.push_back('{sitda_pkg::ASCII_MINUS, 1'b0});
    for (int k = count - 1; k >= 0; k--)
      expected_chars.push_back('{sitda_pkg::ASCII_ZERO + sitda_pkg::TEXT_W'(digits[k]),
                                 k == 0});
  endfunction

  function automatic void queue_typed_text(string text);
    for (int i = 0; i < text.len(); i++)
      expected_chars.push_back('{sitda_pkg::TEXT_W'(text[i]), i == text.len() - 1});
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          ndig;
    int          p;
    v = 64'd0;
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom};
      3, 4: begin
        ndig = $urandom_range(1, 18);
        v    = 64'($urandom_range(1, 9));
        for (int i = 1; i < ndig; i++)
          v = v * RADIX + 64'($urandom_range(0, 9));
      end
      5: v = 64'($urandom_range(0, 20));
      6: begin
        p = $urandom_range(0, 18);
        v = 64'd1;
        for (int i = 0; i < p; i++)
          v = v * RADIX;
        v = v + 64'($urandom_range(0, 2)) - 64'd1;
      end
      7: v = $urandom_range(0, 1) ? VAL_MIN + 64'($urandom_range(0, 15))
                                  : VAL_MAX - 64'($urandom_range(0, 15));
      8: v = {32'hFFFF_FFFF, $urandom};
      default: begin
        v = 64'd1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = ~v;
      end
    endcase
    // flip the sign at random
    if ($urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  // Present one value and hold it until the transfer happens.
  task automatic send_value(logic [63:0] value, string text);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 4) send_calm = $urandom_range(10, 40);
      gap = gap_len();
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value <= value;
    in_push  <= 1'b1;
    do @(posedge clk); while (in_full);
    if (text.len() != 0) queue_typed_text(text);
    else queue_decimal_text(value);
    @(negedge clk);
  endtask

  // Watchdog: count cycles with no transfer on either side.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random pop stalls, check each transfer against the oldest expectation.
  initial begin
    text_char_t want;
    int         stall_left;
    int         calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_pop    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
        else stall_left = gap_len();
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transfer: out_text_byte %0d, out_last_byte %0d",
                 out_text_byte, out_last_byte);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_text_byte !== want.text_byte) begin
            $error("out_text_byte: expected %0d, got %0d", want.text_byte, out_text_byte);
            error_count++;
          end
          if (out_last_byte !== want.last_byte) begin
            $error("out_last_byte: expected %0d, got %0d", want.last_byte, out_last_byte);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_push  = 1'b0;
    in_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int row = 0; row < TABLE_ROWS; row++)
      send_value(table_value[row], table_text[row]);
    for (int n = 0; n < RAND_ITEMS; n++)
      send_value(random_value(), "");
    in_push <= 1'b0;

    // drain, then hold a while so stray extra transfers are caught
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
